>>> design/two_axis_polygon_rect_clip_macros.svh
// Assertion macros for the clip block's controller.
`ifndef TWO_AXIS_POLYGON_RECT_CLIP_MACROS_SVH
`define TWO_AXIS_POLYGON_RECT_CLIP_MACROS_SVH

// Same-cycle implication, clocked on i_clk, off while i_rst_n is low.
`define TAPC_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, clocked on i_clk, off while i_rst_n is low.
`define TAPC_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> design/tapc_pkg.sv
// Types, constants and helpers of the polygon rectangle clipper.
package tapc_pkg;

    localparam int COORD_W     = 16;
    localparam int CRD_W       = 18;
    localparam int DIF_W       = 19;
    localparam int PRD_W       = 38;
    localparam int SUM_W       = 40;
    localparam int MAX_RESULTS = 60;

    typedef logic signed [COORD_W-1:0] t_coord;
    typedef logic signed [CRD_W-1:0]   t_crd;
    typedef logic signed [DIF_W-1:0]   t_dif;
    typedef logic signed [PRD_W-1:0]   t_prd;
    typedef logic signed [SUM_W-1:0]   t_sum;
    typedef logic [1:0]                t_cfg_idx;

    localparam t_cfg_idx CFG_LEFT   = 2'd0;
    localparam t_cfg_idx CFG_TOP    = 2'd1;
    localparam t_cfg_idx CFG_RIGHT  = 2'd2;
    localparam t_cfg_idx CFG_BOTTOM = 2'd3;

    typedef struct packed {
        t_coord x;
        t_coord y;
    } t_vtx;

    typedef struct packed {
        logic load;
        logic load_first;
        logic close;
        logic pass;
        logic rd_pass;
        logic rd_out;
        logic latch_v1;
        logic latch_v2;
        logic adv;
        logic eval;
        logic mul;
        logic div_start;
        logic fix;
        logic sel2;
        logic wr_emit;
        logic wr_cross;
    } t_cmd;

    typedef struct packed {
        logic last_ne;
        logic in_range;
        logic cross1;
        logic cross2;
        logic div_done;
    } t_sts;

    function automatic t_crd crd_of(input t_coord v);
        return {{(CRD_W-COORD_W){v[COORD_W-1]}}, v};
    endfunction

    function automatic t_dif dif_of(input t_crd v);
        return {{(DIF_W-CRD_W){v[CRD_W-1]}}, v};
    endfunction

    function automatic t_sum sum_of_crd(input t_crd v);
        return {{(SUM_W-CRD_W){v[CRD_W-1]}}, v};
    endfunction

    function automatic t_sum sum_of_prd(input t_prd v);
        return {{(SUM_W-PRD_W){v[PRD_W-1]}}, v};
    endfunction

    function automatic t_coord sat16(input t_sum v);
        if (v > t_sum'(32767)) begin
            return t_coord'(16'sh7fff);
        end else if (v < -t_sum'(32768)) begin
            return t_coord'(16'sh8000);
        end
        return v[COORD_W-1:0];
    endfunction

endpackage

>>> design/tapc_div.sv
// Bit-serial signed divider, quotient truncated toward zero, zero divisor gives zero.
module tapc_div (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_start,
    input  tapc_pkg::t_prd i_num,
    input  tapc_pkg::t_dif i_den,
    output tapc_pkg::t_prd o_quo,
    output logic          o_done
);
    import tapc_pkg::*;

    localparam int CNT_W = $clog2(PRD_W);

    logic [PRD_W-1:0] r_qn;
    logic [DIF_W:0]   r_rem;
    logic [DIF_W-1:0] r_dv;
    logic [CNT_W-1:0] r_cnt;
    logic             r_neg;
    logic             r_run;
    logic             r_done;

    logic [DIF_W:0]   rem_sh;
    logic             take;

    assign rem_sh = {r_rem[DIF_W-1:0], r_qn[PRD_W-1]};
    assign take   = rem_sh >= {1'b0, r_dv};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run  <= 1'b0;
            r_done <= 1'b0;
        end else if (i_start) begin
            r_rem <= '0;
            r_cnt <= CNT_W'(PRD_W - 1);
            r_neg <= i_num[PRD_W-1] ^ i_den[DIF_W-1];
            r_dv  <= i_den[DIF_W-1] ? DIF_W'(-i_den) : DIF_W'(i_den);
            if (i_den == '0) begin
                r_qn   <= '0;
                r_run  <= 1'b0;
                r_done <= 1'b1;
            end else begin
                r_qn   <= i_num[PRD_W-1] ? PRD_W'(-i_num) : PRD_W'(i_num);
                r_run  <= 1'b1;
                r_done <= 1'b0;
            end
        end else if (r_run) begin
            r_rem <= take ? rem_sh - {1'b0, r_dv} : rem_sh;
            r_qn  <= {r_qn[PRD_W-2:0], take};
            r_cnt <= r_cnt - 1'b1;
            if (r_cnt == '0) begin
                r_run  <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

    assign o_quo  = r_neg ? -t_prd'(r_qn) : t_prd'(r_qn);
    assign o_done = r_done & ~r_run;

endmodule

>>> design/tapc_dp.sv
// Datapath: window registers, vertex stores, edge registers, crossing arithmetic.
module tapc_dp #(
    parameter int MAX_VERTS = 16,
    localparam int KW = $clog2(4 * MAX_VERTS)
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  tapc_pkg::t_cmd   i_cmd,
    input  logic [KW-1:0]    i_rd_addr,
    input  logic [KW-1:0]    i_wr_addr,
    output tapc_pkg::t_sts   o_sts,
    input  tapc_pkg::t_coord i_vx,
    input  tapc_pkg::t_coord i_vy,
    input  logic             i_cfg_we,
    input  tapc_pkg::t_cfg_idx i_cfg_index,
    input  tapc_pkg::t_coord i_cfg_data,
    output tapc_pkg::t_coord o_ox,
    output tapc_pkg::t_coord o_oy
);
    import tapc_pkg::*;

    localparam int AS = $clog2(MAX_VERTS);
    localparam int A1 = $clog2(2 * MAX_VERTS);

    t_vtx r_src [MAX_VERTS];
    t_vtx r_p1  [2 * MAX_VERTS];
    t_vtx r_p2  [4 * MAX_VERTS];

    t_vtx   r_src_rd, r_p1_rd, r_p2_rd;
    t_vtx   r_first, r_last;
    t_coord r_win_left, r_win_top, r_win_right, r_win_bottom;
    t_crd   r_a1, r_b1, r_a2, r_b2, r_base;
    t_prd   r_prod;
    t_dif   r_den;
    logic   r_dir, r_in, r_c1, r_c2;

    t_crd   lo, hi, rd_a, rd_b, e1, e2;
    t_crd   op_base, op_oth, op_e, op_aa, op_ab;
    t_vtx   rd_v, wr_v;
    t_crd   wr_a;
    t_coord wr_as, wr_bs;
    t_sum   sum;
    t_prd   quo;
    logic   dir, inr, c1, c2, div_done;

    // Widened window for the current pass.
    assign lo = i_cmd.pass ? crd_of(r_win_top) - t_crd'(1) : crd_of(r_win_left) - t_crd'(1);
    assign hi = i_cmd.pass ? crd_of(r_win_bottom) + t_crd'(1)
                           : crd_of(r_win_right) + t_crd'(1);

    assign rd_v = i_cmd.pass ? r_p1_rd : r_src_rd;
    assign rd_a = i_cmd.pass ? crd_of(rd_v.y) : crd_of(rd_v.x);
    assign rd_b = i_cmd.pass ? crd_of(rd_v.x) : crd_of(rd_v.y);

    assign dir = r_a1 > r_a2;
    assign inr = dir ? !(r_a1 < lo || r_a2 > hi) : !(r_a2 < lo || r_a1 > hi);
    assign c1  = dir ? (r_a1 > hi) : (r_a1 < lo);
    assign c2  = dir ? (r_a2 < lo) : (r_a2 > hi);

    assign e1 = r_dir ? hi : lo;
    assign e2 = r_dir ? lo : hi;

    assign op_base = i_cmd.sel2 ? r_b2 : r_b1;
    assign op_oth  = i_cmd.sel2 ? r_b1 : r_b2;
    assign op_e    = i_cmd.sel2 ? e2   : e1;
    assign op_aa   = i_cmd.sel2 ? r_a2 : r_a1;
    assign op_ab   = i_cmd.sel2 ? r_a1 : r_a2;

    assign sum = sum_of_crd(r_base) + sum_of_prd(quo);

    // Emitted point: the edge start, or the crossing on the window edge.
    assign wr_a  = i_cmd.wr_cross ? op_e : r_a1;
    assign wr_as = sat16(sum_of_crd(wr_a));
    assign wr_bs = i_cmd.wr_cross ? sat16(sum) : sat16(sum_of_crd(r_b1));
    assign wr_v  = i_cmd.pass ? t_vtx'{x: wr_bs, y: wr_as} : t_vtx'{x: wr_as, y: wr_bs};

    tapc_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_cmd.div_start),
        .i_num   (r_prod),
        .i_den   (r_den),
        .o_quo   (quo),
        .o_done  (div_done)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_win_left   <= t_coord'(0);
            r_win_top    <= t_coord'(0);
            r_win_right  <= t_coord'(639);
            r_win_bottom <= t_coord'(479);
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_LEFT:   r_win_left   <= i_cfg_data;
                CFG_TOP:    r_win_top    <= i_cfg_data;
                CFG_RIGHT:  r_win_right  <= i_cfg_data;
                CFG_BOTTOM: r_win_bottom <= i_cfg_data;
                default:    r_win_left   <= r_win_left;
            endcase
        end
    end

    // Vertex stores.
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_src[i_wr_addr[AS-1:0]] <= '{x: i_vx, y: i_vy};
        end else if (i_cmd.close) begin
            r_src[i_wr_addr[AS-1:0]] <= r_first;
        end
        if (i_cmd.rd_pass && !i_cmd.pass) begin
            r_src_rd <= r_src[i_rd_addr[AS-1:0]];
        end
    end

    always_ff @(posedge i_clk) begin
        if ((i_cmd.wr_emit || i_cmd.wr_cross) && !i_cmd.pass) begin
            r_p1[i_wr_addr[A1-1:0]] <= wr_v;
        end
        if (i_cmd.rd_pass && i_cmd.pass) begin
            r_p1_rd <= r_p1[i_rd_addr[A1-1:0]];
        end
    end

    always_ff @(posedge i_clk) begin
        if ((i_cmd.wr_emit || i_cmd.wr_cross) && i_cmd.pass) begin
            r_p2[i_wr_addr] <= wr_v;
        end
        if (i_cmd.rd_out) begin
            r_p2_rd <= r_p2[i_rd_addr];
        end
    end

    // Edge registers and crossing operands.
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_last <= '{x: i_vx, y: i_vy};
            if (i_cmd.load_first) begin
                r_first <= '{x: i_vx, y: i_vy};
            end
        end
        if (i_cmd.latch_v1) begin
            r_a1 <= rd_a;
            r_b1 <= rd_b;
        end else if (i_cmd.adv) begin
            r_a1 <= r_a2;
            r_b1 <= r_b2;
        end else if (i_cmd.fix && !i_cmd.sel2) begin
            r_a1 <= e1;
            r_b1 <= sum[CRD_W-1:0];
        end
        if (i_cmd.latch_v2) begin
            r_a2 <= rd_a;
            r_b2 <= rd_b;
        end
        if (i_cmd.eval) begin
            r_dir <= dir;
            r_in  <= inr;
            r_c1  <= c1;
            r_c2  <= c2;
        end
        if (i_cmd.mul) begin
            r_prod <= t_prd'((dif_of(op_oth) - dif_of(op_base)) * (dif_of(op_e) - dif_of(op_aa)));
            r_den  <= dif_of(op_ab) - dif_of(op_aa);
            r_base <= op_base;
        end
    end

    assign o_sts = '{
        last_ne:  (r_last.x != r_first.x) && (r_last.y != r_first.y),
        in_range: r_in,
        cross1:   r_c1,
        cross2:   r_c2,
        div_done: div_done
    };

    assign o_ox = r_p2_rd.x;
    assign o_oy = r_p2_rd.y;

endmodule

>>> design/tapc_ctrl.sv
// Controller: vertex loading, the two clip passes and result output.
`include "two_axis_polygon_rect_clip_macros.svh"

module tapc_ctrl #(
    parameter int MAX_VERTS = 16,
    localparam int KW = $clog2(4 * MAX_VERTS)
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_start,
    input  logic           i_filled,
    input  logic           i_final_vertex,
    input  tapc_pkg::t_sts i_sts,
    output tapc_pkg::t_cmd o_cmd,
    output logic [KW-1:0]  o_rd_addr,
    output logic [KW-1:0]  o_wr_addr,
    output logic           o_busy,
    output logic           o_strobe,
    output logic           o_end
);
    import tapc_pkg::*;

    localparam int CW = $clog2(MAX_VERTS);

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_CLOSE = 4'd1;
    localparam logic [3:0] S_RD0   = 4'd2;
    localparam logic [3:0] S_V1    = 4'd3;
    localparam logic [3:0] S_V2    = 4'd4;
    localparam logic [3:0] S_EVAL  = 4'd5;
    localparam logic [3:0] S_ACT   = 4'd6;
    localparam logic [3:0] S_MUL   = 4'd7;
    localparam logic [3:0] S_DIV   = 4'd8;
    localparam logic [3:0] S_WAIT  = 4'd9;
    localparam logic [3:0] S_FIX   = 4'd10;
    localparam logic [3:0] S_NEXT  = 4'd11;
    localparam logic [3:0] S_E_RD  = 4'd12;
    localparam logic [3:0] S_E_OUT = 4'd13;

    logic [3:0]    r_state, n_state;
    logic [CW-1:0] r_cnt, n_cnt;
    logic [KW-1:0] r_n, n_n, r_i, n_i, r_k, n_k, r_m, n_m;
    logic          r_fill, n_fill, r_pass, n_pass, r_sel2, n_sel2;
    logic          r_ovalid, n_ovalid, r_oend, n_oend;

    logic          ld;
    logic [CW-1:0] cnt_new;
    logic [KW-1:0] i_nxt, i_nxt2;

    assign ld      = r_cnt < CW'(MAX_VERTS - 2);
    assign cnt_new = r_cnt + CW'(ld);
    assign i_nxt   = r_i + KW'(1);
    assign i_nxt2  = r_i + KW'(2);

    always_comb begin
        n_state   = r_state;
        n_cnt     = r_cnt;
        n_n       = r_n;
        n_i       = r_i;
        n_k       = r_k;
        n_m       = r_m;
        n_fill    = r_fill;
        n_pass    = r_pass;
        n_sel2    = r_sel2;
        n_ovalid  = 1'b0;
        n_oend    = 1'b0;
        o_cmd     = '0;
        o_cmd.pass = r_pass;
        o_rd_addr = '0;
        o_wr_addr = '0;

        case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    o_cmd.load       = ld;
                    o_cmd.load_first = (r_cnt == '0);
                    o_wr_addr        = KW'(r_cnt);
                    n_fill           = i_filled;
                    n_cnt            = cnt_new;
                    if (i_final_vertex) begin
                        n_cnt = '0;
                        if (cnt_new >= CW'(2)) begin
                            n_n     = KW'(cnt_new);
                            n_state = S_CLOSE;
                        end
                    end
                end
            end
            S_CLOSE: begin
                if (r_fill && i_sts.last_ne) begin
                    o_cmd.close = 1'b1;
                    o_wr_addr   = r_n;
                    n_n         = r_n + KW'(1);
                end
                n_pass  = 1'b0;
                n_state = S_RD0;
            end
            S_RD0: begin
                o_cmd.rd_pass = 1'b1;
                n_i           = '0;
                n_k           = '0;
                n_state       = S_V1;
            end
            S_V1: begin
                o_cmd.latch_v1 = 1'b1;
                o_cmd.rd_pass  = 1'b1;
                o_rd_addr      = (i_nxt == r_n) ? '0 : i_nxt;
                n_state        = S_V2;
            end
            S_V2: begin
                o_cmd.latch_v2 = 1'b1;
                n_state        = S_EVAL;
            end
            S_EVAL: begin
                o_cmd.eval = 1'b1;
                n_state    = S_ACT;
            end
            S_ACT: begin
                n_state = S_NEXT;
                if (i_sts.in_range) begin
                    o_cmd.wr_emit = 1'b1;
                    o_wr_addr     = r_k;
                    n_k           = r_k + KW'(1);
                    if (i_sts.cross1) begin
                        n_sel2  = 1'b0;
                        n_state = S_MUL;
                    end else if (i_sts.cross2) begin
                        n_sel2  = 1'b1;
                        n_state = S_MUL;
                    end
                end
            end
            S_MUL: begin
                o_cmd.mul  = 1'b1;
                o_cmd.sel2 = r_sel2;
                n_state    = S_DIV;
            end
            S_DIV: begin
                o_cmd.div_start = 1'b1;
                n_state         = S_WAIT;
            end
            S_WAIT: begin
                if (i_sts.div_done) begin
                    n_state = S_FIX;
                end
            end
            S_FIX: begin
                o_cmd.fix      = 1'b1;
                o_cmd.wr_cross = 1'b1;
                o_cmd.sel2     = r_sel2;
                if (!r_sel2) begin
                    // Entry crossing replaces the start point just written.
                    o_wr_addr = r_k - KW'(1);
                    if (i_sts.cross2) begin
                        n_sel2  = 1'b1;
                        n_state = S_MUL;
                    end else begin
                        n_state = S_NEXT;
                    end
                end else begin
                    o_wr_addr = r_k;
                    n_k       = r_k + KW'(1);
                    n_state   = S_NEXT;
                end
            end
            S_NEXT: begin
                o_cmd.adv = 1'b1;
                if (i_nxt == r_n) begin
                    if (!r_pass) begin
                        if (r_k < KW'(3)) begin
                            n_state = S_IDLE;
                        end else begin
                            n_n     = r_k;
                            n_pass  = 1'b1;
                            n_state = S_RD0;
                        end
                    end else if (r_fill ? (r_k <= KW'(2)) : (r_k <= KW'(1))) begin
                        n_state = S_IDLE;
                    end else begin
                        n_m     = (int'(r_k) > MAX_RESULTS) ? KW'(MAX_RESULTS) : r_k;
                        n_i     = '0;
                        n_state = S_E_RD;
                    end
                end else begin
                    n_i           = i_nxt;
                    o_cmd.rd_pass = 1'b1;
                    o_rd_addr     = (i_nxt2 == r_n) ? '0 : i_nxt2;
                    n_state       = S_V2;
                end
            end
            S_E_RD: begin
                o_cmd.rd_out = 1'b1;
                o_rd_addr    = r_i;
                n_ovalid     = 1'b1;
                n_oend       = (r_i == r_m - KW'(1));
                n_state      = S_E_OUT;
            end
            S_E_OUT: begin
                if (r_oend) begin
                    n_state = S_IDLE;
                end else begin
                    n_i     = i_nxt;
                    n_state = S_E_RD;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_cnt    <= '0;
            r_fill   <= 1'b0;
            r_pass   <= 1'b0;
            r_sel2   <= 1'b0;
            r_ovalid <= 1'b0;
            r_oend   <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_cnt    <= n_cnt;
            r_fill   <= n_fill;
            r_pass   <= n_pass;
            r_sel2   <= n_sel2;
            r_ovalid <= n_ovalid;
            r_oend   <= n_oend;
        end
    end

    always_ff @(posedge i_clk) begin
        r_n <= n_n;
        r_i <= n_i;
        r_k <= n_k;
        r_m <= n_m;
    end

    assign o_busy   = (r_state != S_IDLE);
    assign o_strobe = r_ovalid;
    assign o_end    = r_oend;

    `TAPC_ASSERT_IMP(a_strobe_in_out, r_ovalid, r_state == S_E_OUT, "strobe outside output state")
    `TAPC_ASSERT_NXT(a_last_ends, r_ovalid && r_oend, r_state == S_IDLE, "no idle after last item")
    `TAPC_ASSERT_NXT(a_div_wait, r_state == S_DIV, r_state == S_WAIT, "divider start not waited")
    `TAPC_ASSERT_IMP(a_fix_done, r_state == S_FIX, $past(i_sts.div_done), "fix before quotient")

endmodule

>>> design/two_axis_polygon_rect_clip.sv
// Top level of the two-pass polygon / polyline rectangle clipper.
//
//  channel   direction  handshake                     payload
//  vertex    in         start & !busy accepts item    i_vx, i_vy, i_filled, i_final_vertex
//  result    out        o_strobe, one-cycle pulse     o_ox, o_oy, o_end_of_shape
//  config    in         i_cfg_valid & o_cfg_ready     i_cfg_index, i_cfg_data
//
// Loading accepts one vertex item per cycle; busy stays low between vertices.
// A final vertex starts clipping: each pass reads its first vertex, then steps
// through every edge; each window crossing adds a multiply and a division by the
// divider, one quotient bit per cycle (38 quotient bits); a zero divisor skips it.
// Results then leave one at a time, each after a registered read of the output store.
// Reset is synchronous and active low; the vertex stores are not cleared.
// Results cannot be held off: each strobe lasts exactly one cycle.
module two_axis_polygon_rect_clip #(
    parameter int MAX_VERTS = 16
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    // vertex items
    input  logic             start,
    output logic             busy,
    input  tapc_pkg::t_coord i_vx,
    input  tapc_pkg::t_coord i_vy,
    input  logic             i_filled,
    input  logic             i_final_vertex,
    // clipped vertex items
    output logic             o_strobe,
    output tapc_pkg::t_coord o_ox,
    output tapc_pkg::t_coord o_oy,
    output logic             o_end_of_shape,
    // window register writes
    input  logic             i_cfg_valid,
    output logic             o_cfg_ready,
    input  tapc_pkg::t_cfg_idx i_cfg_index,
    input  tapc_pkg::t_coord i_cfg_data
);
    import tapc_pkg::*;

    localparam int KW = $clog2(4 * MAX_VERTS);

    t_cmd          cmd;
    t_sts          sts;
    logic [KW-1:0] rd_addr;
    logic [KW-1:0] wr_addr;

    // Window writes are taken only while no shape is being clipped.
    assign o_cfg_ready = ~busy;

    tapc_ctrl #(
        .MAX_VERTS (MAX_VERTS)
    ) u_ctrl (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_start        (start),
        .i_filled       (i_filled),
        .i_final_vertex (i_final_vertex),
        .i_sts          (sts),
        .o_cmd          (cmd),
        .o_rd_addr      (rd_addr),
        .o_wr_addr      (wr_addr),
        .o_busy         (busy),
        .o_strobe       (o_strobe),
        .o_end          (o_end_of_shape)
    );

    tapc_dp #(
        .MAX_VERTS (MAX_VERTS)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .i_rd_addr   (rd_addr),
        .i_wr_addr   (wr_addr),
        .o_sts       (sts),
        .i_vx        (i_vx),
        .i_vy        (i_vy),
        .i_cfg_we    (i_cfg_valid & o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_ox        (o_ox),
        .o_oy        (o_oy)
    );

endmodule

>>> tb/tb_two_axis_polygon_rect_clip_checker.sv
`timescale 1ns / 1ps
// Clip checker: predicts clipped vertices per shape and compares the result items.
module tb_two_axis_polygon_rect_clip_checker (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  logic               i_busy,
    input  tapc_pkg::t_coord   i_vx,
    input  tapc_pkg::t_coord   i_vy,
    input  logic               i_filled,
    input  logic               i_final_vertex,
    input  logic               i_strobe,
    input  tapc_pkg::t_coord   i_ox,
    input  tapc_pkg::t_coord   i_oy,
    input  logic               i_end_of_shape,
    input  logic               i_cfg_valid,
    input  logic               i_cfg_ready,
    input  tapc_pkg::t_cfg_idx i_cfg_index,
    input  tapc_pkg::t_coord   i_cfg_data,
    output int                 o_fail_count,
    output int                 o_pending,
    output logic               o_activity
);
    import tapc_pkg::*;

    localparam int KEEP_MAX = 14;   // MAX_VERTS - 2

    typedef struct {
        t_coord x;
        t_coord y;
        logic   eos;
    } t_clip_vtx;

    t_clip_vtx clipped_q[$];

    int win_l, win_t, win_r, win_b;
    int shape_x[16], shape_y[16];
    int edge_x[32], edge_y[32];
    int kept;
    logic fill_sel;

    // scratch for one axis pass
    int in_a[64], in_b[64], out_a[64], out_b[64];

    function automatic int sat_coord(input longint v);
        if (v > 32767) return 32767;
        if (v < -32768) return -32768;
        return int'(v);
    endfunction

    function automatic longint trunc_div(input longint num, input longint den);
        return (den == 0) ? 0 : num / den;
    endfunction

    // clips in_a (the clipped axis) / in_b into out_a / out_b
    function automatic int clip_axis(input int n, input longint lo, input longint hi,
                                     input int cap);
        int k;
        int j;
        longint a1, b1, a2, b2, na, nb;
        k = 0;
        j = 1;
        a1 = in_a[0];
        b1 = in_b[0];
        for (int i = 0; i < n; i++) begin
            a2 = in_a[j];
            b2 = in_b[j];
            j++;
            if (j >= n) j = 0;
            na = a2;
            nb = b2;
            if (a1 > a2) begin
                if (!(a1 < lo || a2 > hi)) begin
                    if (k < cap) begin
                        out_a[k] = sat_coord(a1); out_b[k] = sat_coord(b1); k++;
                    end
                    if (a1 > hi) begin
                        b1 = b1 + trunc_div((b2 - b1) * (hi - a1), a2 - a1);
                        a1 = hi;
                        if (k > 0) begin
                            out_a[k-1] = sat_coord(a1); out_b[k-1] = sat_coord(b1);
                        end
                    end
                    if (a2 < lo) begin
                        b2 = b2 + trunc_div((b1 - b2) * (lo - a2), a1 - a2);
                        a2 = lo;
                        if (k < cap) begin
                            out_a[k] = sat_coord(a2); out_b[k] = sat_coord(b2); k++;
                        end
                    end
                end
            end else begin
                if (!(a2 < lo || a1 > hi)) begin
                    if (k < cap) begin
                        out_a[k] = sat_coord(a1); out_b[k] = sat_coord(b1); k++;
                    end
                    if (a1 < lo) begin
                        b1 = b1 + trunc_div((b2 - b1) * (lo - a1), a2 - a1);
                        a1 = lo;
                        if (k > 0) begin
                            out_a[k-1] = sat_coord(a1); out_b[k-1] = sat_coord(b1);
                        end
                    end
                    if (a2 > hi) begin
                        b2 = b2 + trunc_div((b1 - b2) * (hi - a2), a1 - a2);
                        a2 = hi;
                        if (k < cap) begin
                            out_a[k] = sat_coord(a2); out_b[k] = sat_coord(b2); k++;
                        end
                    end
                end
            end
            a1 = na;
            b1 = nb;
        end
        return k;
    endfunction

    task automatic predict_vertex(input t_coord vx, input t_coord vy,
                                  input logic filled, input logic fin);
        int n, n1, n2;
        t_clip_vtx v;
        fill_sel = filled;
        if (kept < KEEP_MAX) begin
            shape_x[kept] = vx;
            shape_y[kept] = vy;
            kept++;
        end
        if (!fin) return;
        n = kept;
        kept = 0;
        if (n < 2) return;
        // polygon closes itself only when both coordinates differ
        if (fill_sel && shape_x[n-1] != shape_x[0] && shape_y[n-1] != shape_y[0]) begin
            shape_x[n] = shape_x[0];
            shape_y[n] = shape_y[0];
            n++;
        end
        for (int i = 0; i < n; i++) begin
            in_a[i] = shape_x[i];
            in_b[i] = shape_y[i];
        end
        n1 = clip_axis(n, longint'(win_l) - 1, longint'(win_r) + 1, 32);
        if (n1 < 3) return;
        for (int i = 0; i < n1; i++) begin
            edge_x[i] = out_a[i];
            edge_y[i] = out_b[i];
        end
        for (int i = 0; i < n1; i++) begin
            in_a[i] = edge_y[i];
            in_b[i] = edge_x[i];
        end
        n2 = clip_axis(n1, longint'(win_t) - 1, longint'(win_b) + 1, 64);
        if (fill_sel ? (n2 <= 2) : (n2 <= 1)) return;
        if (n2 > MAX_RESULTS) n2 = MAX_RESULTS;
        for (int i = 0; i < n2; i++) begin
            v.x = t_coord'(out_b[i]);
            v.y = t_coord'(out_a[i]);
            v.eos = (i == n2 - 1);
            clipped_q.push_back(v);
        end
    endtask

    task automatic report_mismatch(input string what);
        $display("MISMATCH at %0t: %s", $realtime, what);
        o_fail_count++;
    endtask

    always @(posedge i_clk) begin
        t_clip_vtx e;
        if (!i_rst_n) begin
            win_l = 0; win_t = 0; win_r = 639; win_b = 479;
            kept = 0;
            fill_sel = 1'b0;
            clipped_q.delete();
            o_activity <= 1'b0;
        end else begin
            o_activity <= (i_start && !i_busy) || i_strobe || (i_cfg_valid && i_cfg_ready);
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_index)
                    CFG_LEFT:   win_l = i_cfg_data;
                    CFG_TOP:    win_t = i_cfg_data;
                    CFG_RIGHT:  win_r = i_cfg_data;
                    CFG_BOTTOM: win_b = i_cfg_data;
                    default: ;
                endcase
            end
            if (i_strobe) begin
                if (clipped_q.size() == 0) begin
                    report_mismatch($sformatf("unexpected item x=%0d y=%0d", i_ox, i_oy));
                end else begin
                    e = clipped_q.pop_front();
                    if (i_ox !== e.x)
                        report_mismatch($sformatf("ox %0d, want %0d", i_ox, e.x));
                    if (i_oy !== e.y)
                        report_mismatch($sformatf("oy %0d, want %0d", i_oy, e.y));
                    if (i_end_of_shape !== e.eos)
                        report_mismatch($sformatf("end_of_shape %0b, want %0b",
                                                  i_end_of_shape, e.eos));
                end
            end
            if (i_start && !i_busy)
                predict_vertex(i_vx, i_vy, i_filled, i_final_vertex);
        end
        o_pending <= clipped_q.size();
    end

    initial begin
        o_fail_count = 0;
        o_pending = 0;
        o_activity = 1'b0;
    end
endmodule

>>> tb/tb_two_axis_polygon_rect_clip.sv
`timescale 1ns / 1ps
// Testbench top: vertex and window stimulus for the rectangle clipper, verdict.
module tb_two_axis_polygon_rect_clip;
    import tapc_pkg::*;

    // quiet time after the last result: meant to cover the worst shape, every edge
    // and window crossing included, even a shape that gives no result
    localparam int SETTLE_CYCLES = 6000;
    localparam int STALL_LIMIT   = 20000;
    localparam int RANDOM_ITEMS  = 310;

    logic     i_clk;
    logic     i_rst_n;
    logic     start;
    logic     busy;
    t_coord   i_vx, i_vy;
    logic     i_filled, i_final_vertex;
    logic     o_strobe;
    t_coord   o_ox, o_oy;
    logic     o_end_of_shape;
    logic     i_cfg_valid;
    logic     o_cfg_ready;
    t_cfg_idx i_cfg_index;
    t_coord   i_cfg_data;

    int   fail_count;
    int   pending;
    logic activity;
    int   stall_cnt;
    int   sent;
    bit   no_gaps;          // stretches of back-to-back items
    int   wl, wt, wr, wb;   // current window, for aiming the random vertices

    two_axis_polygon_rect_clip dut (
        .i_clk, .i_rst_n, .start, .busy, .i_vx, .i_vy, .i_filled, .i_final_vertex,
        .o_strobe, .o_ox, .o_oy, .o_end_of_shape,
        .i_cfg_valid, .o_cfg_ready, .i_cfg_index, .i_cfg_data
    );

    tb_two_axis_polygon_rect_clip_checker u_checker (
        .i_clk, .i_rst_n, .i_start(start), .i_busy(busy), .i_vx, .i_vy, .i_filled,
        .i_final_vertex, .i_strobe(o_strobe), .i_ox(o_ox), .i_oy(o_oy),
        .i_end_of_shape(o_end_of_shape), .i_cfg_valid, .i_cfg_ready(o_cfg_ready),
        .i_cfg_index, .i_cfg_data, .o_fail_count(fail_count), .o_pending(pending),
        .o_activity(activity)
    );

    always begin
        i_clk = 1'b1; #5;
        i_clk = 1'b0; #5;
    end

    // watchdog: cycles with no handshake of any kind
    always @(posedge i_clk) begin
        if (activity) stall_cnt <= 0;
        else stall_cnt <= stall_cnt + 1;
        if (stall_cnt >= STALL_LIMIT) begin
            $display("Test completed with failures");
            $finish;
        end
    end

    // mostly short gaps, a few long ones
    function automatic int pick_gap();
        if (no_gaps) return 0;
        if ($urandom_range(0, 9) < 8) return $urandom_range(0, 2);
        return $urandom_range(3, 40);
    endfunction

    // vertex item: held until the block takes it at an edge with busy low
    task automatic send_vertex(input int x, input int y, input logic f, input logic fin);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        start          <= 1'b1;
        i_vx           <= t_coord'(x);
        i_vy           <= t_coord'(y);
        i_filled       <= f;
        i_final_vertex <= fin;
        @(negedge i_clk);
        while (busy) @(negedge i_clk);
        @(posedge i_clk);
        sent++;
    endtask

    task automatic write_reg(input t_cfg_idx idx, input int val);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= t_coord'(val);
        @(negedge i_clk);
        while (!o_cfg_ready) @(negedge i_clk);
        @(posedge i_clk);
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    // window change only once the block has drained
    task automatic set_window(input int l, input int t, input int r, input int b);
        start <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        write_reg(CFG_LEFT, l);
        write_reg(CFG_TOP, t);
        write_reg(CFG_RIGHT, r);
        write_reg(CFG_BOTTOM, b);
        wl = l; wt = t; wr = r; wb = b;
    endtask

    // coordinate aimed around an axis of the window, sometimes anywhere
    function automatic int pick_coord(input int lo, input int hi);
        int a, b;
        if ($urandom_range(0, 7) == 0) return $urandom_range(0, 65535) - 32768;
        a = (lo < hi) ? lo : hi;
        b = (lo < hi) ? hi : lo;
        return a - 200 + int'($urandom_range(0, b - a + 400));
    endfunction

    // one random shape; count sometimes beyond the 14 kept vertices
    task automatic random_shape();
        int n;
        logic f;
        n = ($urandom_range(0, 9) == 0) ? $urandom_range(15, 18) : $urandom_range(1, 9);
        f = $urandom_range(0, 1);
        for (int i = 0; i < n; i++) begin
            // occasional broken shapes: filled bit flips mid-shape
            if ($urandom_range(0, 19) == 0) f = ~f;
            send_vertex(pick_coord(wl, wr), pick_coord(wt, wb), f, i == n - 1);
        end
    endtask

    task automatic random_phase(input int items);
        int target;
        target = sent + items;
        while (sent < target) begin
            if ($urandom_range(0, 7) == 0) no_gaps = ~no_gaps;
            random_shape();
        end
        no_gaps = 0;
    endtask

    initial begin
        i_rst_n = 1'b0;
        start = 1'b0;
        i_vx = '0; i_vy = '0; i_filled = 1'b0; i_final_vertex = 1'b0;
        i_cfg_valid = 1'b0; i_cfg_index = CFG_LEFT; i_cfg_data = '0;
        stall_cnt = 0; sent = 0; no_gaps = 0;
        wl = 0; wt = 0; wr = 639; wb = 479;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed, reset window
        // square inside: last vertex shares x with the first, so no closing copy is added
        send_vertex(10, 10, 1, 0); send_vertex(100, 10, 1, 0);
        send_vertex(100, 100, 1, 0); send_vertex(10, 100, 1, 1);
        // triangle crossing every edge of the window
        send_vertex(-500, 240, 1, 0); send_vertex(320, -400, 1, 0);
        send_vertex(1200, 900, 1, 1);
        // polyline through the window, extreme coordinates
        send_vertex(-32768, -32768, 0, 0); send_vertex(32767, 32767, 0, 0);
        send_vertex(32767, -32768, 0, 1);
        // single vertex: short shape
        send_vertex(50, 50, 0, 1);
        // shape entirely outside
        send_vertex(700, 10, 1, 0); send_vertex(800, 20, 1, 0); send_vertex(900, 5, 1, 1);
        // more vertices than are kept, the last two dropped
        for (int i = 0; i < 16; i++)
            send_vertex((i * 97) % 700 - 30, (i * 61) % 520 - 20, 1, i == 15);
        random_phase(60);

        // full range window: widened edges lie beyond 16 bits
        set_window(-32768, -32768, 32767, 32767);
        send_vertex(-32768, 0, 1, 0); send_vertex(0, 32767, 1, 0);
        send_vertex(32767, -32768, 1, 1);
        random_phase(50);

        // inverted window: left beyond right, top beyond bottom
        set_window(300, 200, 100, 50);
        random_phase(50);

        // tiny window
        set_window(5, -7, 5, -7);
        random_phase(50);

        // upper extreme corner, then reset values back
        set_window(32000, 32000, 32767, 32767);
        random_phase(40);
        set_window(0, 0, 639, 479);
        random_phase(RANDOM_ITEMS - 250);

        start <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end
endmodule

>>> files.f
+incdir+design
design/tapc_pkg.sv
design/tapc_div.sv
design/tapc_dp.sv
design/tapc_ctrl.sv
design/two_axis_polygon_rect_clip.sv
tb/tb_two_axis_polygon_rect_clip_checker.sv
tb/tb_two_axis_polygon_rect_clip.sv
